// File: rtl/core/co2ci_pkg.sv
// ----------------------------------------------------------------------------
// co2ci_pkg - shared definitions for the CO2 confinement index core
// Widths, register map, reset values, calendar and threshold tables.
// ----------------------------------------------------------------------------
package co2ci_pkg;

    localparam int WINDOW_COUNT_BITS = 24;
    localparam int N_BITS     = WINDOW_COUNT_BITS + 2;  // good + fair + poor
    localparam int S_BITS     = WINDOW_COUNT_BITS + 3;  // n + fair + 3*poor
    localparam int LEVEL_BITS = 18;                     // Q2.16 thresholds
    localparam int CMP_BITS   = N_BITS + LEVEL_BITS;
    localparam int LEVELS     = 5;
    localparam int ADDR_BITS  = 4;

    localparam logic [WINDOW_COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd600;
    localparam logic [15:0] GOOD_LIMIT_RESET    = 16'd1000;
    localparam logic [15:0] POOR_LIMIT_RESET    = 16'd1700;

    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] REG_GOOD_LIMIT    = 2'd1;
    localparam logic [1:0] REG_POOR_LIMIT    = 2'd2;

    localparam logic [2:0] WD_SUNDAY   = 3'd0;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    // 2^(0.2 + 0.4k), k = 0..4, rounded to nearest in Q2.16
    localparam logic [LEVEL_BITS-1:0] LEVEL_Q16 [LEVELS] = '{
        18'd75281, 18'd99334, 18'd131072, 18'd172951, 18'd228210
    };

    typedef struct packed {
        logic [15:0] window_length;
        logic [15:0] good_limit_ppm;
        logic [15:0] poor_limit_ppm;
    } cfg_t;

    typedef struct packed {
        logic                         updated;
        logic [WINDOW_COUNT_BITS-1:0] good;
        logic [WINDOW_COUNT_BITS-1:0] fair;
        logic [WINDOW_COUNT_BITS-1:0] poor;
    } win_snap_t;

    // Sakamoto month offsets, month already clamped to 1..12
    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] off;
        case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

// File: rtl/core/co2ci_weekday.sv
// ----------------------------------------------------------------------------
// co2ci_weekday - weekend detector
// Sakamoto day-of-week from the calendar date, flags Saturday and Sunday.
// ----------------------------------------------------------------------------
module co2ci_weekday (
    input  logic [4:0]  day_of_month,
    input  logic [3:0]  month_number,
    input  logic [11:0] year_number,
    output logic        weekend
);

    logic [3:0]  month_c;
    logic [11:0] year_adj;
    logic [24:0] year_mul;
    logic [5:0]  cent;
    logic [3:0]  quad_cent;
    logic [12:0] day_sum;
    logic [26:0] sum_mul;
    logic [10:0] quot7;
    logic [12:0] rem_full;
    logic [2:0]  wday;

    always_comb begin
        if (month_number == 4'd0) begin
            month_c = 4'd1;
        end else if (month_number > 4'd12) begin
            month_c = 4'd12;
        end else begin
            month_c = month_number;
        end

        // Jan and Feb count against the year before; year zero wraps to zero
        if (month_c < 4'd3) begin
            year_adj = (year_number == 12'd0) ? 12'd0 : year_number - 12'd1;
        end else begin
            year_adj = year_number;
        end

        // y/100 by reciprocal, exact for 12-bit years
        year_mul  = 25'(year_adj) * 25'(13'd5243);
        cent      = year_mul[24:19];
        quad_cent = cent[5:2];

        day_sum = 13'(year_adj) + 13'(year_adj[11:2]) - 13'(cent) + 13'(quad_cent)
                + 13'(co2ci_pkg::month_offset(month_c)) + 13'(day_of_month);

        // mod 7 by reciprocal, exact over the range of day_sum
        sum_mul  = 27'(day_sum) * 27'(14'd9363);
        quot7    = sum_mul[26:16];
        rem_full = day_sum - 13'(quot7) * 13'd7;
        wday     = rem_full[2:0];

        weekend = (wday == co2ci_pkg::WD_SUNDAY) || (wday == co2ci_pkg::WD_SATURDAY);
    end

endmodule

// File: rtl/core/co2ci_window.sv
// ----------------------------------------------------------------------------
// co2ci_window - window accumulator and classifier
// Sums weekday samples, classes each closed window and bumps its counter.
// ----------------------------------------------------------------------------
module co2ci_window (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  sample_en,
    input  logic [15:0]           co2_ppm,
    input  co2ci_pkg::cfg_t       cfg,
    output co2ci_pkg::win_snap_t  snap
);

    logic [31:0] sample_sum_reg, sample_sum_next;
    logic [15:0] sample_count_reg, sample_count_next;
    logic [co2ci_pkg::WINDOW_COUNT_BITS-1:0] good_reg, fair_reg, poor_reg;

    logic [15:0] len;
    logic [15:0] count_inc;
    logic [31:0] sum_inc;
    logic [31:0] good_bound;
    logic [31:0] poor_bound;
    logic        close;

    always_comb begin
        len       = (cfg.window_length == 16'd0) ? 16'd1 : cfg.window_length;
        count_inc = sample_count_reg + 16'd1;
        sum_inc   = sample_sum_reg + 32'(co2_ppm);
        close     = (count_inc >= len);

        // average compared through count * limit, no division
        good_bound = 32'(count_inc) * 32'(cfg.good_limit_ppm);
        poor_bound = 32'(count_inc) * 32'(cfg.poor_limit_ppm);

        snap.updated = sample_en && close;
        snap.good    = good_reg;
        snap.fair    = fair_reg;
        snap.poor    = poor_reg;
        if (sum_inc <= good_bound) begin
            snap.good = (good_reg == co2ci_pkg::COUNT_MAX) ? good_reg : good_reg + 1'b1;
        end else if (sum_inc < poor_bound) begin
            snap.fair = (fair_reg == co2ci_pkg::COUNT_MAX) ? fair_reg : fair_reg + 1'b1;
        end else begin
            snap.poor = (poor_reg == co2ci_pkg::COUNT_MAX) ? poor_reg : poor_reg + 1'b1;
        end

        sample_count_next = close ? 16'd0 : count_inc;
        sample_sum_next   = close ? 32'd0 : sum_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            good_reg         <= '0;
            fair_reg         <= '0;
            poor_reg         <= '0;
        end else if (sample_en) begin
            sample_sum_reg   <= sample_sum_next;
            sample_count_reg <= sample_count_next;
            if (close) begin
                good_reg <= snap.good;
                fair_reg <= snap.fair;
                poor_reg <= snap.poor;
            end
        end
    end

endmodule

// File: rtl/core/co2ci_index.sv
// ----------------------------------------------------------------------------
// co2ci_index - confinement level compare
// Counts the thresholds N * 2^(0.2+0.4k) that S reaches, giving 0..5.
// ----------------------------------------------------------------------------
module co2ci_index (
    input  logic [co2ci_pkg::N_BITS-1:0] n_total,
    input  logic [co2ci_pkg::S_BITS-1:0] s_weighted,
    output logic [2:0]                   index
);

    logic [co2ci_pkg::CMP_BITS-1:0] lhs;
    logic [co2ci_pkg::CMP_BITS-1:0] rhs [co2ci_pkg::LEVELS];
    logic [2:0]                     hits;

    always_comb begin
        lhs  = co2ci_pkg::CMP_BITS'({s_weighted, 16'd0});
        hits = 3'd0;
        for (int k = 0; k < co2ci_pkg::LEVELS; k++) begin
            rhs[k] = co2ci_pkg::CMP_BITS'(n_total)
                   * co2ci_pkg::CMP_BITS'(co2ci_pkg::LEVEL_Q16[k]);
            hits   = hits + 3'(lhs >= rhs[k]);
        end
        // no windows yet: index stays at the best level
        index = (n_total == '0) ? 3'd0 : hits;
    end

endmodule

// File: rtl/core/co2_confinement_index_core.sv
// ----------------------------------------------------------------------------
// co2_confinement_index_core - CO2 confinement index top level
// Throughput: one word per cycle while m_tready does not stall the result
// stream; the window counters are updated as each weekday sample moves on,
// so back-to-back samples follow each other with no gap.
// Reset: synchronous active-low aresetn clears the pipeline, accumulators,
// window counters and index, and loads the register reset values.
// ----------------------------------------------------------------------------
module co2_confinement_index_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: co2_ppm[15:0], day_of_month[20:16], month_number[24:21],
    //          year_number[36:25], zero pad[39:37]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,
    // m_tdata: confinement_index[2:0], index_updated[3], weekend_skipped[4],
    //          zero pad[7:5]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [co2ci_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    co2ci_pkg::cfg_t cfg_reg;

    // stage 0: input word
    logic        v0_reg;
    logic [39:0] in_reg;
    // stage 1: sample and weekend flag
    logic        v1_reg;
    logic [15:0] co2_reg;
    logic        wkend_reg;
    // stage 2: counter snapshot
    logic                 v2_reg;
    logic                 skip2_reg;
    co2ci_pkg::win_snap_t snap_reg;
    // stage 3: weighted sums
    logic                         v3_reg;
    logic                         skip3_reg;
    logic                         upd3_reg;
    logic [co2ci_pkg::N_BITS-1:0] n_reg;
    logic [co2ci_pkg::S_BITS-1:0] s_reg;
    // output stage
    logic       out_v_reg;
    logic [7:0] out_reg;
    logic [2:0] index_reg;

    logic rdy4, rdy3, rdy2, rdy1;
    logic weekend;
    logic sample_en;
    logic [2:0] index_new;
    logic [2:0] index_out;
    logic [co2ci_pkg::N_BITS-1:0] n_next;
    logic [co2ci_pkg::S_BITS-1:0] s_next;
    co2ci_pkg::win_snap_t snap;

    // each stage takes a word when empty or when it is moving on
    assign rdy4     = !out_v_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = !v0_reg || rdy1;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
    assign pready   = 1'b1;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length  <= co2ci_pkg::WINDOW_LENGTH_RESET;
            cfg_reg.good_limit_ppm <= co2ci_pkg::GOOD_LIMIT_RESET;
            cfg_reg.poor_limit_ppm <= co2ci_pkg::POOR_LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                co2ci_pkg::REG_WINDOW_LENGTH: cfg_reg.window_length  <= pwdata[15:0];
                co2ci_pkg::REG_GOOD_LIMIT:    cfg_reg.good_limit_ppm <= pwdata[15:0];
                co2ci_pkg::REG_POOR_LIMIT:    cfg_reg.poor_limit_ppm <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            co2ci_pkg::REG_WINDOW_LENGTH: prdata = 32'(cfg_reg.window_length);
            co2ci_pkg::REG_GOOD_LIMIT:    prdata = 32'(cfg_reg.good_limit_ppm);
            co2ci_pkg::REG_POOR_LIMIT:    prdata = 32'(cfg_reg.poor_limit_ppm);
            default:                      prdata = 32'd0;
        endcase
    end

    co2ci_weekday u_weekday (
        .day_of_month (in_reg[20:16]),
        .month_number (in_reg[24:21]),
        .year_number  (in_reg[36:25]),
        .weekend      (weekend)
    );

    // accumulator state moves exactly once per weekday word
    assign sample_en = v1_reg && rdy2 && !wkend_reg;

    co2ci_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sample_en (sample_en),
        .co2_ppm   (co2_reg),
        .cfg       (cfg_reg),
        .snap      (snap)
    );

    assign n_next = co2ci_pkg::N_BITS'(snap_reg.good) + co2ci_pkg::N_BITS'(snap_reg.fair)
                  + co2ci_pkg::N_BITS'(snap_reg.poor);
    assign s_next = co2ci_pkg::S_BITS'(n_next) + co2ci_pkg::S_BITS'(snap_reg.fair)
                  + co2ci_pkg::S_BITS'(snap_reg.poor) * co2ci_pkg::S_BITS'(2'd3);

    co2ci_index u_index (
        .n_total    (n_reg),
        .s_weighted (s_reg),
        .index      (index_new)
    );

    assign index_out = upd3_reg ? index_new : index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            index_reg <= 3'd0;
        end else begin
            if (s_tready) begin
                v0_reg <= s_tvalid;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                out_v_reg <= v3_reg;
                if (v3_reg && upd3_reg) begin
                    index_reg <= index_new;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= s_tdata;
        end
        if (rdy1 && v0_reg) begin
            co2_reg   <= in_reg[15:0];
            wkend_reg <= weekend;
        end
        if (rdy2 && v1_reg) begin
            skip2_reg <= wkend_reg;
            snap_reg  <= snap;
        end
        if (rdy3 && v2_reg) begin
            skip3_reg <= skip2_reg;
            upd3_reg  <= snap_reg.updated;
            n_reg     <= n_next;
            s_reg     <= s_next;
        end
        if (rdy4 && v3_reg) begin
            out_reg <= {3'd0, skip3_reg, upd3_reg, index_out};
        end
    end

endmodule

// File: rtl/core/co2ci_checker.sv
// ----------------------------------------------------------------------------
// co2ci_checker - port-level checks for the confinement index core
// Watches the result stream and configuration port; bound to the top level.
// ----------------------------------------------------------------------------
module co2ci_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       pready
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // a weekend tick never closes a window
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("updated and skipped both set");

    // index stays within 0..5
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= 3'd5))
        else $error("index out of range");

    // index only moves on a word that closed a window
    a_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready ##1 m_tvalid && !m_tdata[3]
        |-> m_tdata[2:0] == $past(m_tdata[2:0]))
        else $error("index changed without a window close");

    a_ready: assert property (@(posedge aclk) pready)
        else $error("pready dropped");

endmodule

bind co2_confinement_index_core co2ci_checker u_co2ci_checker (.*);

// File: tb/sv/co2_confinement_index_core_tb.sv
// ----------------------------------------------------------------------------
// co2_confinement_index_core_tb - self-checking bench for the index core
// Drives calendar-stamped CO2 words with random gaps and back-pressure,
// reprograms the window and limit registers between phases over APB, and
// checks every result word against an in-bench weekday, window and index
// predictor.
// ----------------------------------------------------------------------------
module co2_confinement_index_core_tb;

    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 100;
    localparam int PHASES       = 8;

    typedef struct packed {
        bit          drain_first;
        logic [7:0]  gap;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] co2;
    } tick_t;

    typedef struct packed {
        logic [2:0] index;
        logic       updated;
        logic       skipped;
    } index_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [co2ci_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    co2_confinement_index_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of the registers and the window state
    logic [15:0] cfg_window_len = co2ci_pkg::WINDOW_LENGTH_RESET;
    logic [15:0] cfg_good_limit = co2ci_pkg::GOOD_LIMIT_RESET;
    logic [15:0] cfg_poor_limit = co2ci_pkg::POOR_LIMIT_RESET;
    logic [31:0] acc_sum    = '0;
    logic [15:0] acc_count  = '0;
    logic [co2ci_pkg::WINDOW_COUNT_BITS-1:0] good_cnt = '0;
    logic [co2ci_pkg::WINDOW_COUNT_BITS-1:0] fair_cnt = '0;
    logic [co2ci_pkg::WINDOW_COUNT_BITS-1:0] poor_cnt = '0;
    logic [2:0]  held_index = '0;

    int month_shift [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    // 2^(0.2 + 0.4k) in Q2.16
    longint unsigned index_level [5] = '{75281, 99334, 131072, 172951, 228210};

    tick_t         tick_q [$];
    index_result_t index_expect_q [$];
    int            mismatch_count = 0;

    tick_t tx_cur;
    bit    tx_loaded = 1'b0;
    int    tx_gap    = 0;
    bit    tx_fast   = 1'b1;
    bit    s_fired   = 1'b0;

    bit    rx_fast     = 1'b1;
    bit    rx_took     = 1'b0;
    bit    rx_hold_req = 1'b0;
    int    rx_wait     = 0;
    int    rx_hold     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("co2_confinement_index_core_tb: FAIL");
        $finish;
    end

    function automatic logic [2:0] day_of_week(input logic [4:0] d, input logic [3:0] m,
                                               input logic [11:0] y);
        int unsigned mm, yy, total;
        logic [2:0]  wd;
        mm = 32'(m);
        yy = 32'(y);
        if (mm < 1) mm = 1;
        if (mm > 12) mm = 12;
        // Jan and Feb count with the previous year; year 0 wraps to 0
        if (mm < 3) yy = yy - 1;
        if (yy > 32'hFFFFF) yy = 0;
        total = yy + yy / 4 - yy / 100 + yy / 400 + month_shift[mm - 1] + 32'(d);
        wd = 3'(total % 7);
        return wd;
    endfunction

    function automatic index_result_t predict_index(input tick_t t);
        index_result_t   r;
        logic [2:0]      wd;
        logic [15:0]     len;
        longint unsigned sum64, cnt64, gw, fw, pw, n, s;
        logic [2:0]      idx;
        wd = day_of_week(t.day, t.month, t.year);
        r.updated = 1'b0;
        r.skipped = 1'b0;
        if (wd == co2ci_pkg::WD_SUNDAY || wd == co2ci_pkg::WD_SATURDAY) begin
            r.skipped = 1'b1;
        end else begin
            len = (cfg_window_len == 16'd0) ? 16'd1 : cfg_window_len;
            acc_count = acc_count + 16'd1;
            acc_sum   = acc_sum + 32'(t.co2);
            if (acc_count >= len) begin
                sum64 = 64'(acc_sum);
                cnt64 = 64'(acc_count);
                if (sum64 <= cnt64 * 64'(cfg_good_limit)) begin
                    if (good_cnt != co2ci_pkg::COUNT_MAX) good_cnt = good_cnt + 1'b1;
                end else if (sum64 < cnt64 * 64'(cfg_poor_limit)) begin
                    if (fair_cnt != co2ci_pkg::COUNT_MAX) fair_cnt = fair_cnt + 1'b1;
                end else begin
                    if (poor_cnt != co2ci_pkg::COUNT_MAX) poor_cnt = poor_cnt + 1'b1;
                end
                gw = 64'(good_cnt);
                fw = 64'(fair_cnt);
                pw = 64'(poor_cnt);
                n  = gw + fw + pw;
                s  = n + fw + 3 * pw;
                idx = 3'd0;
                if (n != 0) begin
                    for (int k = 0; k < 5; k++) begin
                        if ((s << 16) >= n * index_level[k]) idx = idx + 3'd1;
                    end
                end
                held_index = idx;
                acc_count  = '0;
                acc_sum    = '0;
                r.updated  = 1'b1;
            end
        end
        r.index = held_index;
        return r;
    endfunction

    function automatic void queue_tick(input logic [15:0] co2, input logic [4:0] d,
                                       input logic [3:0] m, input logic [11:0] y);
        tick_t t;
        t.co2         = co2;
        t.day         = d;
        t.month       = m;
        t.year        = y;
        t.gap         = tx_fast ? 8'd0 : 8'($urandom_range(0, 10));
        t.drain_first = ($urandom_range(0, 39) == 0);
        tick_q.push_back(t);
    endfunction

    // mostly weekday dates so windows close; returns 1 for a weekday word
    function automatic bit queue_random_tick();
        logic [4:0]  d;
        logic [3:0]  m;
        logic [11:0] y;
        logic [2:0]  wd;
        bit          want_weekday;
        int          tries;
        int          v;
        want_weekday = ($urandom_range(0, 5) != 0);
        tries = 0;
        do begin
            d = ($urandom_range(0, 63) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
            m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 12));
            y = ($urandom_range(0, 6) == 0) ? 12'($urandom_range(0, 4095))
                                            : 12'($urandom_range(1900, 4095));
            wd = day_of_week(d, m, y);
            tries++;
        end while (want_weekday && (wd == co2ci_pkg::WD_SUNDAY ||
                                    wd == co2ci_pkg::WD_SATURDAY) && tries < 16);
        case ($urandom_range(0, 7))
            0:       v = int'($urandom_range(0, 65535));
            1, 2:    v = int'(cfg_good_limit) + int'($urandom_range(0, 300)) - 150;
            3, 4:    v = int'(cfg_poor_limit) + int'($urandom_range(0, 300)) - 150;
            default: v = int'($urandom_range(200, 3000));
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        queue_tick(v[15:0], d, m, y);
        return !(wd == co2ci_pkg::WD_SUNDAY || wd == co2ci_pkg::WD_SATURDAY);
    endfunction

    task automatic apb_write(input logic [1:0] reg_idx, input logic [15:0] value);
        logic [31:0] word;
        word = $urandom();
        word[15:0] = value;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (reg_idx)
            co2ci_pkg::REG_WINDOW_LENGTH: cfg_window_len = value;
            co2ci_pkg::REG_GOOD_LIMIT:    cfg_good_limit = value;
            co2ci_pkg::REG_POOR_LIMIT:    cfg_poor_limit = value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tick_q.size() != 0 || tx_loaded || index_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // sender: one word at a time, optional gap, optional drain before offering
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fired) begin
                s_fired   = 1'b0;
                tx_loaded = 1'b0;
            end
            if (!tx_loaded && tick_q.size() != 0) begin
                tx_cur    = tick_q.pop_front();
                tx_loaded = 1'b1;
                tx_gap    = int'(tx_cur.gap);
            end
            if (tx_loaded && tx_gap == 0 &&
                (!tx_cur.drain_first || index_expect_q.size() == 0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, tx_cur.year, tx_cur.month, tx_cur.day, tx_cur.co2};
            end else begin
                s_tvalid <= 1'b0;
                if (tx_loaded && tx_gap > 0) tx_gap--;
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (rx_took) begin
            rx_took = 1'b0;
            rx_wait = rx_fast ? 0 : int'($urandom_range(0, 10));
        end
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold     = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // predict on input accept, check on output accept
    always @(posedge aclk) begin
        index_result_t exp_r;
        tick_t         t;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                t = '0;
                {t.year, t.month, t.day, t.co2} = s_tdata[36:0];
                index_expect_q.push_back(predict_index(t));
                s_fired = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                rx_took = 1'b1;
                if (index_expect_q.size() == 0) begin
                    $error("unexpected result word 0x%02h", m_tdata);
                    mismatch_count++;
                end else begin
                    exp_r = index_expect_q.pop_front();
                    if (m_tdata[2:0] !== exp_r.index) begin
                        $error("confinement_index: expected %0d, actual %0d",
                               exp_r.index, m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[3] !== exp_r.updated) begin
                        $error("index_updated: expected %0d, actual %0d",
                               exp_r.updated, m_tdata[3]);
                        mismatch_count++;
                    end
                    if (m_tdata[4] !== exp_r.skipped) begin
                        $error("weekend_skipped: expected %0d, actual %0d",
                               exp_r.skipped, m_tdata[4]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic [15:0] len, gl, pl;
        int          weekday_words;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: weekday decode, weekend skip, month clamps, year edges
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        queue_tick(16'd0,     5'd1,  4'd1,  12'd2024);
        queue_tick(16'hFFFF,  5'd31, 4'd12, 12'd4095);
        queue_tick(16'd1500,  5'd6,  4'd1,  12'd2024);
        queue_tick(16'd1500,  5'd7,  4'd1,  12'd2024);
        queue_tick(16'd800,   5'd15, 4'd0,  12'd2000);
        queue_tick(16'd800,   5'd15, 4'd13, 12'd2000);
        queue_tick(16'd800,   5'd16, 4'd14, 12'd2001);
        queue_tick(16'd800,   5'd31, 4'd15, 12'd4095);
        queue_tick(16'd900,   5'd1,  4'd1,  12'd0);
        queue_tick(16'd900,   5'd9,  4'd5,  12'd0);
        queue_tick(16'd900,   5'd1,  4'd2,  12'd1900);
        wait_idle();

        // one-sample windows straddling both limits
        apb_write(co2ci_pkg::REG_WINDOW_LENGTH, 16'd1);
        queue_tick(16'd1000,  5'd1, 4'd1, 12'd2024);
        queue_tick(16'd1001,  5'd2, 4'd1, 12'd2024);
        queue_tick(16'd1699,  5'd3, 4'd1, 12'd2024);
        queue_tick(16'd1700,  5'd4, 4'd1, 12'd2024);
        queue_tick(16'd0,     5'd5, 4'd1, 12'd2024);
        queue_tick(16'hFFFF,  5'd1, 4'd1, 12'd2024);
        wait_idle();

        // zero length behaves as one
        apb_write(co2ci_pkg::REG_WINDOW_LENGTH, 16'd0);
        queue_tick(16'd400,   5'd2, 4'd1, 12'd2024);
        queue_tick(16'd2500,  5'd3, 4'd1, 12'd2024);
        wait_idle();

        // length lowered under the running count closes on the next sample
        apb_write(co2ci_pkg::REG_WINDOW_LENGTH, 16'hFFFF);
        queue_tick(16'd1200,  5'd1, 4'd1, 12'd2024);
        queue_tick(16'd1300,  5'd2, 4'd1, 12'd2024);
        queue_tick(16'd1400,  5'd3, 4'd1, 12'd2024);
        wait_idle();
        apb_write(co2ci_pkg::REG_WINDOW_LENGTH, 16'd2);
        queue_tick(16'd1500,  5'd4, 4'd1, 12'd2024);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin len = 16'd1; gl = 16'd1000;  pl = 16'd1700;  end
                1: begin len = 16'd3; gl = 16'd900;   pl = 16'd1200;  end
                2: begin len = 16'd2; gl = 16'd0;     pl = 16'd0;     end
                3: begin len = 16'd4; gl = 16'hFFFF;  pl = 16'hFFFF;  end
                4: begin len = 16'd0; gl = 16'd1700;  pl = 16'd1000;  end
                default: begin
                    len = 16'($urandom_range(1, 8));
                    gl  = 16'($urandom_range(300, 2000));
                    pl  = gl + 16'($urandom_range(0, 1000));
                end
            endcase
            apb_write(co2ci_pkg::REG_WINDOW_LENGTH, len);
            apb_write(co2ci_pkg::REG_GOOD_LIMIT, gl);
            apb_write(co2ci_pkg::REG_POOR_LIMIT, pl);
            tx_fast = (phase == 0 || phase == 1 || phase == 5);
            rx_fast = (phase == 0 || phase == 6);
            // long sink stall while the source keeps streaming
            if (phase == 1) rx_hold_req = 1'b1;
            weekday_words = 0;
            while (weekday_words < PHASE_WORDS) begin
                if (queue_random_tick()) weekday_words++;
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("co2_confinement_index_core_tb: PASS");
        end else begin
            $display("co2_confinement_index_core_tb: FAIL");
        end
        $finish;
    end

endmodule
